// File: rtl/prta_pkg.sv
package prta_pkg;

  localparam int STATION_COUNT_DEF = 64;
  localparam int RATE_COUNT_DEF    = 16;
  localparam int COUNTER_WIDTH_DEF = 16;

  localparam int RATE_W    = 4;
  localparam int CREDIT_W  = 4;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Sample and credit thresholds of the rate rule
  localparam int ENOUGH_SAMPLES = 10;
  localparam int CREDIT_GOAL    = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST  = 2'd3;

  localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd1000000;
  localparam logic [RATE_W-1:0] INIT_RST     = 4'd0;
  localparam logic [RATE_W-1:0] LOWEST_RST   = 4'd0;
  localparam logic [RATE_W-1:0] HIGHEST_RST  = 4'd15;

  typedef struct packed {
    logic        func;
    logic [5:0]  station;
    logic [31:0] now;
    logic [7:0]  retries;
    logic        success;
    logic        given_up;
  } in_t;

  typedef struct packed {
    logic [3:0] rate;
    logic       rate_changed;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0] interval_ticks;
    logic [RATE_W-1:0] initial_rate;
    logic [RATE_W-1:0] lowest_rate;
    logic [RATE_W-1:0] highest_rate;
  } cfg_t;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

endpackage

// File: rtl/prta_ram.sv
module prta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/prta_eval.sv
module prta_eval import prta_pkg::*; #(
  parameter int RATE_COUNT    = RATE_COUNT_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
  localparam int CW = COUNTER_WIDTH,
  localparam int ENTRY_W = TIME_W + 3 * CW + CREDIT_W + RATE_W
) (
  input  in_t                item,
  input  logic               is_new,
  input  cfg_t               cfg,
  input  logic [ENTRY_W-1:0] entry_in,
  output logic [ENTRY_W-1:0] entry_out,
  output logic [RATE_W-1:0]  rate,
  output logic               changed
);

  localparam logic [RATE_W-1:0] TOP_RATE =
    (RATE_COUNT - 1 > 15) ? RATE_W'(15) : RATE_W'(RATE_COUNT - 1);

  logic [RATE_W-1:0]   rate_b, rate_n, init_c;
  logic [CREDIT_W-1:0] credit_b, credit_n;
  logic [CW-1:0]       retr_b, succ_b, drop_b;
  logic [CW-1:0]       retr_a, succ_a, drop_a;
  logic [TIME_W-1:0]   start_b, start_n, elapsed;
  logic [CW:0]         retr_sum, samples;
  logic [CW+4:0]       raise_lim;
  logic [CREDIT_W:0]   credit_inc;
  logic                report, due, enough, lower, raise_ok, clr;

  always_comb begin
    init_c = (cfg.initial_rate > TOP_RATE) ? TOP_RATE : cfg.initial_rate;
    if (is_new) begin
      rate_b   = init_c;
      credit_b = '0;
      retr_b   = '0;
      succ_b   = '0;
      drop_b   = '0;
      start_b  = item.now;
    end else begin
      {start_b, drop_b, succ_b, retr_b, credit_b, rate_b} = entry_in;
    end

    report = !item.func && (item.success || item.given_up);

    // saturating counter updates
    retr_sum = {1'b0, retr_b} + (CW+1)'(item.retries);
    retr_a   = report ? (retr_sum[CW] ? '1 : retr_sum[CW-1:0]) : retr_b;
    succ_a   = (report && item.success && succ_b != '1) ? succ_b + CW'(1) : succ_b;
    drop_a   = (report && !item.success && drop_b != '1) ? drop_b + CW'(1) : drop_b;

    elapsed = item.now - start_b;
    due     = report && (elapsed >= cfg.interval_ticks);

    samples   = {1'b0, succ_a} + {1'b0, drop_a};
    enough    = samples >= (CW+1)'(ENOUGH_SAMPLES);
    lower     = (drop_a != '0 && succ_a == '0) || (enough && succ_a < retr_a);
    // retr < succ/10  <=>  (retr + 1) * 10 <= succ
    raise_lim = ({5'b0, retr_a} + (CW+5)'(1)) * (CW+5)'(10);
    raise_ok  = enough && drop_a == '0 && raise_lim <= {5'b0, succ_a};
    credit_inc = {1'b0, credit_b} + (CREDIT_W+1)'(1);

    rate_n   = rate_b;
    credit_n = credit_b;
    start_n  = start_b;
    clr      = 1'b0;
    if (due) begin
      start_n = item.now;
      priority if (lower) begin
        if (rate_b > cfg.lowest_rate && rate_b != '0) begin
          rate_n = rate_b - RATE_W'(1);
        end
        credit_n = '0;
      end else if (raise_ok) begin
        if (credit_inc >= (CREDIT_W+1)'(CREDIT_GOAL)) begin
          if (rate_b < cfg.highest_rate && rate_b < TOP_RATE) begin
            rate_n = rate_b + RATE_W'(1);
          end
          credit_n = '0;
        end else begin
          credit_n = credit_inc[CREDIT_W-1:0];
        end
      end else if (enough && credit_b != '0) begin
        credit_n = credit_b - CREDIT_W'(1);
      end
      clr = (rate_n != rate_b) || enough;
    end

    entry_out = clr ? {start_n, {(3*CW){1'b0}}, credit_n, rate_n}
                    : {start_n, drop_a, succ_a, retr_a, credit_n, rate_n};
    rate    = rate_n;
    changed = is_new || (rate_n != rate_b);
  end

endmodule

// File: rtl/per_station_tx_rate_adaptation_top.sv
// Per-station transmit-rate selector (credit-based rate control).
//
// Input channel (in_valid/in_ready/in_data): one transaction is either a
// completion report (func = 0) or a rate query (func = 1) for one station.
// Output channel (out_valid/out_ready/out_data): exactly one result per input
// transaction, in order: the station's rate after the transaction and a flag
// that marks a newly created or changed rate. Out-of-range stations give 0/0.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 interval_ticks, 1 initial_rate, 2 lowest_rate, 3 highest_rate).
//
// One transaction at a time: no new one is accepted until the last result is
// loaded. The accept cycle issues the read of the station entry from the
// single-port-per-side state RAM; S_EVAL then runs the update rule, writes the
// entry back and loads the output register, and out_valid rises as it does so.
// Stall: the output register holds one finished result; a new transaction is
// still accepted while it waits, and the block sits in the update cycle until
// the output register frees up.
// Reset: synchronous, active low. Config and control registers return to their defaults and all
// stations become unknown (per-station valid flops); no RAM clearing pass.
module per_station_tx_rate_adaptation_top import prta_pkg::*; #(
  parameter int STATION_COUNT = STATION_COUNT_DEF,
  parameter int RATE_COUNT    = RATE_COUNT_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int STA_AW  = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
  localparam int ENTRY_W = TIME_W + 3 * COUNTER_WIDTH + CREDIT_W + RATE_W;
  localparam logic [RATE_W-1:0] TOP_RATE =
    (RATE_COUNT - 1 > 15) ? RATE_W'(15) : RATE_W'(RATE_COUNT - 1);

  state_t state_r, state_nxt;
  in_t    item_r;
  out_t   out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;
  cfg_t   cfg_r;
  logic [STATION_COUNT-1:0] entry_valid_r;

  logic               in_acc, load, in_range;
  logic [31:0]        sta_in_ext, sta_item_ext;
  logic [STA_AW-1:0]  rd_idx, item_idx;
  logic [ENTRY_W-1:0] entry_rd, entry_wr;
  logic [RATE_W-1:0]  new_rate;
  logic               new_changed, ram_we;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // station index into the table, sized to the table depth
  assign sta_in_ext   = 32'(in_data.station);
  assign sta_item_ext = 32'(item_r.station);
  assign rd_idx       = sta_in_ext[STA_AW-1:0];
  assign item_idx     = sta_item_ext[STA_AW-1:0];
  assign in_range     = sta_item_ext < 32'(STATION_COUNT);

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{INTERVAL_RST, INIT_RST, LOWEST_RST, HIGHEST_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL: cfg_r.interval_ticks <= cfg_data;
        CFG_INIT:     cfg_r.initial_rate   <= cfg_data[RATE_W-1:0];
        CFG_LOWEST:   cfg_r.lowest_rate    <= cfg_data[RATE_W-1:0];
        CFG_HIGHEST:  cfg_r.highest_rate   <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- station state memory: read at accept, written back in S_EVAL ----
  prta_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STATION_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_idx),
    .wdata (entry_wr),
    .re    (in_acc),
    .raddr (rd_idx),
    .rdata (entry_rd)
  );

  prta_eval #(
    .RATE_COUNT   (RATE_COUNT),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_eval (
    .item      (item_r),
    .is_new    (!entry_valid_r[item_idx]),
    .cfg       (cfg_r),
    .entry_in  (entry_rd),
    .entry_out (entry_wr),
    .rate      (new_rate),
    .changed   (new_changed)
  );

  // ---- control ----
  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!out_valid_r || out_ready) begin
          load          = 1'b1;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = in_range ? '{new_rate, new_changed} : '{'0, 1'b0};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ram_we = load && in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        entry_valid_r[item_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a new result only appears at the end of an update cycle
  a_load_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EVAL))
    else $error("result loaded outside update cycle");

  // a written station is known from then on
  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> entry_valid_r[$past(item_idx)])
    else $error("station not marked valid after write");

  // rates stay within the usable range
  a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.rate <= TOP_RATE)
    else $error("rate above top usable index");
`endif

endmodule
